// File: src/wlhn_pkg.sv
// Shared types, constants and codes of the waterline height normalizer.
package wlhn_pkg;

	localparam int unsigned MAX_POINTS_DEF = 4096;

	localparam int unsigned HW  = 16;  // stored height width
	localparam int unsigned WLW = 17;  // waterline width
	localparam int unsigned XW  = 18;  // width of height differences
	localparam int unsigned NW  = 26;  // dividend width of the normalizer
	localparam int unsigned DW  = 18;  // divisor width of the normalizer
	localparam int unsigned DCW = $clog2(NW);
	localparam logic [WLW-1:0] WL_TOP = WLW'(32768);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	localparam logic [1:0] CFG_WATER = 2'd0;
	localparam logic [1:0] CFG_FLOOR = 2'd1;
	localparam logic [1:0] CFG_CEIL  = 2'd2;

	typedef struct packed {
		logic accept;
		logic mm_init;
		logic scan_clr;
		logic scan;
		logic mode_cnt;
		logic srch_upd;
		logic close_done;
		logic rd_issue;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic srch_done;
		logic err;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// File: src/wlhn_ctrl.sv
// Sequencer of the normalizer: load, map closing passes and read division.
module wlhn_ctrl
	import wlhn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic op,
	input  logic last_point,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_CL_INIT   = 13'b0000000000010,
		S_MM_SCAN   = 13'b0000000000100,
		S_MM_DRAIN  = 13'b0000000001000,
		S_CHK       = 13'b0000000010000,
		S_CNT_SCAN  = 13'b0000000100000,
		S_CNT_DRAIN = 13'b0000001000000,
		S_CNT_UPD   = 13'b0000010000000,
		S_FIN       = 13'b0000100000000,
		S_RD_CHK    = 13'b0001000000000,
		S_DIV_INIT  = 13'b0010000000000,
		S_DIV       = 13'b0100000000000,
		S_DONE      = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (op == OP_READ)
						state_d = S_RD_CHK;
					else if (last_point)
						state_d = S_CL_INIT;
				end
			end
			S_CL_INIT: begin
				cmd.mm_init  = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d      = S_MM_SCAN;
			end
			S_MM_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last)
					state_d = S_MM_DRAIN;
			end
			S_MM_DRAIN: state_d = S_CHK;
			S_CHK: begin
				cmd.scan_clr = 1'b1;
				state_d      = sts.srch_done ? S_FIN : S_CNT_SCAN;
			end
			S_CNT_SCAN: begin
				cmd.scan     = 1'b1;
				cmd.mode_cnt = 1'b1;
				if (sts.scan_last)
					state_d = S_CNT_DRAIN;
			end
			S_CNT_DRAIN: state_d = S_CNT_UPD;
			S_CNT_UPD: begin
				cmd.srch_upd = 1'b1;
				state_d      = S_CHK;
			end
			S_FIN: begin
				cmd.close_done = 1'b1;
				state_d        = S_IDLE;
			end
			S_RD_CHK: begin
				cmd.rd_issue = 1'b1;
				state_d      = sts.err ? S_DONE : S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: src/wlhn_dp.sv
// Datapath: height store, map statistics, waterline search and divider.
module wlhn_dp
	import wlhn_pkg::*;
#(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  op,
	input  logic signed [15:0]    height,
	input  logic [11:0]           index,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [7:0]     norm_height,
	output logic [1:0]            status,
	output logic signed [16:0]    waterline_out
);

	localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
	localparam int unsigned AW  = $clog2(MAX_POINTS);
	localparam int unsigned PNW = CW + 7;

	logic [HW-1:0] mem [MAX_POINTS];

	logic [6:0]            pct_q;
	logic signed [7:0]     floor_q;
	logic [6:0]            ceil_q;
	logic [CW-1:0]         count_q;
	logic                  ready_q;
	logic signed [HW-1:0]  min_q, max_q;
	logic [WLW-1:0]        wl_q;
	logic [WLW-1:0]        lo_q, hi_q;
	logic [PNW-1:0]        pn_q;
	logic [CW-1:0]         below_q;
	logic [CW-1:0]         scan_idx_q;
	logic                  scan_vld_s1, scan_cnt_s1;
	logic [HW-1:0]         rd_data_q;
	logic [11:0]           idx_q;
	status_t               status_q;
	logic [NW-1:0]         quo_q;
	logic [DW-1:0]         den_q, rem_q;
	logic                  neg_q;
	logic [DCW-1:0]        div_cnt_q;
	logic                  out_valid_q;
	logic signed [7:0]     norm_q;
	status_t               ostat_q;
	logic [WLW-1:0]        owl_q;

	logic [CW-1:0]         base;
	logic [6:0]            pct_c;
	logic [WLW-1:0]        mid;
	logic signed [XW-1:0]  rd_x, mid_x, h_x, w_x, min_x, max_x, diff, den_s;
	logic                  h_below;
	logic signed [7:0]     fac;
	logic signed [NW-1:0]  prod;
	logic [DW+1:0]         trial;
	logic [NW-1:0]         qres;
	logic [AW-1:0]         rd_addr;
	logic                  out_free;

	// A load after a complete map starts a new one.
	assign base  = ready_q ? '0 : count_q;
	assign pct_c = (pct_q == 7'd0) ? 7'd1 : ((pct_q > 7'd100) ? 7'd100 : pct_q);
	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_x  = XW'($signed(rd_data_q));
	assign mid_x = $signed({1'b0, mid});

	assign h_x     = rd_x;
	assign w_x     = $signed({1'b0, wl_q});
	assign min_x   = XW'(min_q);
	assign max_x   = XW'(max_q);
	assign diff    = h_x - w_x;
	assign h_below = (h_x <= w_x);
	assign fac     = h_below ? floor_q : $signed({1'b0, ceil_q});
	assign prod    = NW'(diff * fac);
	assign den_s   = h_below ? (min_x - w_x) : (max_x - w_x);

	assign trial = {1'b0, rem_q, quo_q[NW-1]} - {2'b00, den_q};
	assign qres  = neg_q ? (~quo_q + NW'(1)) : quo_q;

	assign rd_addr  = cmd.rd_issue ? AW'(idx_q) : scan_idx_q[AW-1:0];
	assign out_free = !out_valid_q || out_ready;

	assign sts.scan_last = ((scan_idx_q + CW'(1)) == count_q);
	assign sts.srch_done = (lo_q == hi_q);
	assign sts.err       = (status_q != ST_OK);
	assign sts.div_done  = (div_cnt_q == DCW'(NW - 1));
	assign sts.out_free  = out_free;

	always_ff @(posedge clk) begin
		if (cmd.accept && op == OP_LOAD && base < CW'(MAX_POINTS))
			mem[base[AW-1:0]] <= height;
		if (cmd.scan || cmd.rd_issue)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q       <= 7'd50;
			floor_q     <= -8'sd20;
			ceil_q      <= 7'd20;
			count_q     <= '0;
			ready_q     <= 1'b0;
			min_q       <= '0;
			max_q       <= '0;
			wl_q        <= WLW'(1);
			scan_vld_s1 <= 1'b0;
			scan_cnt_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			div_cnt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_WATER: pct_q   <= cfg_data[6:0];
					CFG_FLOOR: floor_q <= cfg_data;
					CFG_CEIL:  ceil_q  <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (op == OP_LOAD) begin
					ready_q <= 1'b0;
					count_q <= (base < CW'(MAX_POINTS)) ? base + CW'(1) : base;
				end else if (!ready_q)
					status_q <= ST_NOT_READY;
				else if (32'(index) >= 32'(count_q))
					status_q <= ST_RANGE;
				else
					status_q <= ST_OK;
			end
			if (cmd.mm_init) begin
				min_q <= '0;
				max_q <= '0;
			end
			scan_vld_s1 <= cmd.scan;
			scan_cnt_s1 <= cmd.mode_cnt;
			if (scan_vld_s1 && !scan_cnt_s1) begin
				if ($signed(rd_data_q) < min_q) min_q <= $signed(rd_data_q);
				if ($signed(rd_data_q) > max_q) max_q <= $signed(rd_data_q);
			end
			if (cmd.close_done) begin
				wl_q    <= lo_q;
				ready_q <= 1'b1;
			end
			if (cmd.div_init)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + DCW'(1);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Search state, divider and result payload.
	always_ff @(posedge clk) begin
		if (cmd.accept)
			idx_q <= index;
		if (cmd.mm_init) begin
			lo_q <= WLW'(1);
			hi_q <= WL_TOP;
			pn_q <= PNW'(pct_c) * PNW'(count_q);
		end
		if (cmd.scan_clr) begin
			scan_idx_q <= '0;
			below_q    <= '0;
		end else begin
			if (cmd.scan)
				scan_idx_q <= scan_idx_q + CW'(1);
			if (scan_vld_s1 && scan_cnt_s1 && rd_x < mid_x)
				below_q <= below_q + CW'(1);
		end
		if (cmd.srch_upd) begin
			if (PNW'(below_q) * PNW'(100) >= pn_q)
				hi_q <= mid;
			else
				lo_q <= mid + WLW'(1);
		end
		if (cmd.div_init) begin
			quo_q <= prod[NW-1] ? NW'(-prod) : NW'(prod);
			den_q <= den_s[XW-1] ? DW'(-den_s) : DW'(den_s);
			rem_q <= '0;
			neg_q <= prod[NW-1] ^ den_s[XW-1];
		end else if (cmd.div_step) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			norm_q  <= (status_q == ST_OK) ? $signed(qres[7:0]) : 8'sd0;
			ostat_q <= status_q;
			owl_q   <= wl_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign norm_height   = norm_q;
	assign status        = ostat_q;
	assign waterline_out = $signed(owl_q);

endmodule

// File: src/waterline_height_normalizer_top.sv
// Waterline height normalizer: top level joining sequencer and datapath.
//
// Input channel (in_valid/in_ready) takes one request per handshake. A load
// request (op 0) stores height; loads can follow every cycle. A load with
// last_point closes the map: one scan for minimum and maximum, then 15 search
// steps, each a counting scan over the stored points; in_ready stays low
// throughout. A read request (op 1) gives one result on the output channel
// (out_valid/out_ready), computed by the 26-step serial divider; a read that
// fails its checks skips the divider and gives its error result directly.
// The result sits in an output register, so the next request is taken while
// a result waits; a stalled receiver only holds the block once a finished
// result needs the register. Configuration writes (cfg_valid/cfg_ready) are
// always taken; the user must keep them to idle periods, which the block does
// not enforce. Reset clears the map state and returns the configuration
// registers to their defaults; no clearing pass follows.
module waterline_height_normalizer_top
	import wlhn_pkg::*;
#(
	parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic signed [15:0] height,
	input  logic               last_point,
	input  logic [11:0]        index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [7:0]  norm_height,
	output logic [1:0]         status,
	output logic signed [16:0] waterline_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	wlhn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.last_point (last_point),
		.sts        (sts),
		.cmd        (cmd)
	);

	wlhn_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.height        (height),
		.index         (index),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.norm_height   (norm_height),
		.status        (status),
		.waterline_out (waterline_out)
	);

endmodule

// File: src/wlhn_chk.sv
// Port-level checker of the normalizer and its binding to the top level.
module wlhn_chk
	import wlhn_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [7:0]  norm_height,
	input logic [1:0]         status,
	input logic signed [16:0] waterline_out
);

	// A result never carries an undefined status code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_NOT_READY || status == ST_RANGE))
		else $error("invalid status code");

	// Error results carry a zero height.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (norm_height == 8'sd0))
		else $error("error result with nonzero height");

	// A successful read reports a waterline of at least one.
	a_wl_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_OK) |-> (waterline_out >= 17'sd1))
		else $error("waterline below one on a good result");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(norm_height) && $stable(status)))
		else $error("stalled result changed");

	// A fresh result is only produced while the input side is busy with a read.
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the input side was idle");

endmodule

bind waterline_height_normalizer_top wlhn_chk u_chk (.*);
